// ===== rtl/pxc_pkg.sv =====
// Shared types and constants for the packed pixel to RGBA16 converter.
`timescale 1ns / 1ps
package pxc_pkg;

   localparam int CHAN_W    = 16;
   localparam int NUM_CHAN  = 4;
   localparam int NUM_COL   = 3;
   localparam int WORD_W    = 64;
   localparam int LAYOUT_W  = 13;
   localparam int ADDR_W    = 5;
   localparam int DATA_W    = 32;

   localparam int CH_RED    = 0;
   localparam int CH_GREEN  = 1;
   localparam int CH_BLUE   = 2;
   localparam int CH_ALPHA  = 3;

   // divider: quotient bits resolved per stage, and stage count
   localparam int DIV_BITS   = 4;
   localparam int DIV_STAGES = CHAN_W / DIV_BITS;

   localparam logic [3:0]          RST_BYTES_PER_PIXEL = 4'd3;
   localparam logic                RST_BIG_ENDIAN      = 1'b1;
   localparam logic [LAYOUT_W-1:0] RST_RED_LAYOUT      = 13'd528;
   localparam logic [LAYOUT_W-1:0] RST_GREEN_LAYOUT    = 13'd520;
   localparam logic [LAYOUT_W-1:0] RST_BLUE_LAYOUT     = 13'd512;
   localparam logic [LAYOUT_W-1:0] RST_ALPHA_LAYOUT    = 13'd0;
   localparam logic                RST_PREMULTIPLIED   = 1'b0;

   typedef enum logic [2:0] {
      REG_BYTES_PER_PIXEL = 3'd0,
      REG_BIG_ENDIAN      = 3'd1,
      REG_RED_LAYOUT      = 3'd2,
      REG_GREEN_LAYOUT    = 3'd3,
      REG_BLUE_LAYOUT     = 3'd4,
      REG_ALPHA_LAYOUT    = 3'd5,
      REG_PREMULTIPLIED   = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic [3:0]                          bytes_per_pixel;
      logic                                big_endian;
      logic [NUM_CHAN-1:0][LAYOUT_W-1:0]   layout;
      logic                                premultiplied;
   } cfg_type;

   typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] chan_vec_type;

endpackage

// ===== rtl/pxc_unpack.sv =====
// Three-stage unpack pipe: byte assembly, field extraction, 16-bit expansion.
`timescale 1ns / 1ps
module pxc_unpack (
   input  logic                       clock,
   input  logic                       reset,
   input  pxc_pkg::cfg_type           cfg,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic [pxc_pkg::WORD_W-1:0] in_raw,
   output logic                       out_valid,
   input  logic                       out_ready,
   output pxc_pkg::chan_vec_type      out_chan
);

   logic [2:0] valid_ff, valid_in;
   logic [2:0] en;

   logic [pxc_pkg::WORD_W-1:0]      word_ff, word_in;
   pxc_pkg::chan_vec_type           field_ff, field_in;
   logic [pxc_pkg::NUM_CHAN-1:0][4:0] wid_ff, wid_in;
   pxc_pkg::chan_vec_type           chan_ff, chan_in;

   // widen a w-bit field to 16 bits; 0 reads as all ones.
   // 1..8: MSB-first replication. 9..15: field at the top, OR'd with its
   // upper bits shifted down into the low byte.
   function automatic logic [15:0] expand(input logic [15:0] v, input logic [4:0] w);
      logic [15:0] r;
      logic [15:0] top;
      r = v;
      top = v;
      if (w == 5'd0) r = 16'hFFFF;
      for (int k = 1; k < 16; k++) begin
         if (w == 5'(k)) begin
            top = v << (16 - k);
            if (k <= 8) begin
               r = '0;
               for (int i = 0; i < 16; i++) begin
                  if (i * k < 16) r = r | (top >> (i * k));
               end
            end else begin
               r = (v >> (k - 8)) | top;
            end
         end
      end
      return r;
   endfunction

   // stall control: a stage moves when empty or when the next one moves
   always_comb begin
      en[2] = !valid_ff[2] || out_ready;
      en[1] = !valid_ff[1] || en[2];
      en[0] = !valid_ff[0] || en[1];
      valid_in[0] = en[0] ? in_valid    : valid_ff[0];
      valid_in[1] = en[1] ? valid_ff[0] : valid_ff[1];
      valid_in[2] = en[2] ? valid_ff[1] : valid_ff[2];
   end

   assign in_ready  = en[0];
   assign out_valid = valid_ff[2];
   assign out_chan  = chan_ff;

   // stage 1: byte assembly
   always_comb begin
      logic [2:0] last;
      logic [2:0] src;
      if (cfg.bytes_per_pixel == 4'd0)      last = 3'd0;
      else if (cfg.bytes_per_pixel > 4'd8) last = 3'd7;
      else                                  last = 3'(cfg.bytes_per_pixel - 4'd1);
      word_in = '0;
      for (int j = 0; j < 8; j++) begin
         src = cfg.big_endian ? 3'(last - 3'(j)) : 3'(j);
         if (3'(j) <= last) word_in[8*j +: 8] = in_raw[8*src +: 8];
      end
   end

   // stage 2: field extraction
   always_comb begin
      logic [6:0]  widc;
      logic [6:0]  sh;
      logic [63:0] shifted;
      logic [15:0] f;
      for (int c = 0; c < pxc_pkg::NUM_CHAN; c++) begin
         widc = (cfg.layout[c][12:6] > 7'd64) ? 7'd64 : cfg.layout[c][12:6];
         if (widc <= 7'd16) sh = {1'b0, cfg.layout[c][5:0]};
         else               sh = 7'({1'b0, cfg.layout[c][5:0]} + widc - 7'd16);
         shifted = word_ff >> sh[5:0];
         f = sh[6] ? 16'd0 : shifted[15:0];
         if (widc < 7'd16) f = f & 16'((17'd1 << widc[3:0]) - 17'd1);
         field_in[c] = f;
         wid_in[c]   = (widc >= 7'd16) ? 5'd16 : widc[4:0];
      end
   end

   // stage 3: expansion
   always_comb begin
      for (int c = 0; c < pxc_pkg::NUM_CHAN; c++) chan_in[c] = expand(field_ff[c], wid_ff[c]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) word_ff <= word_in;
      if (en[1]) begin
         field_ff <= field_in;
         wid_ff   <= wid_in;
      end
      if (en[2]) chan_ff <= chan_in;
   end

endmodule

// ===== rtl/pxc_unpremul.sv =====
// Pipelined divider undoing premultiplied alpha: colour = min(65535, 65535*c/a).
`timescale 1ns / 1ps
module pxc_unpremul (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  premultiplied,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  pxc_pkg::chan_vec_type in_chan,
   output logic                  out_valid,
   input  logic                  out_ready,
   output pxc_pkg::chan_vec_type out_chan
);

   localparam int NS = pxc_pkg::DIV_STAGES;

   typedef struct packed {
      logic [pxc_pkg::NUM_COL-1:0][15:0] rem;
      logic [pxc_pkg::NUM_COL-1:0][15:0] low;
      logic [pxc_pkg::NUM_COL-1:0][15:0] quo;
      logic [pxc_pkg::NUM_COL-1:0]       sat;
      logic [pxc_pkg::NUM_COL-1:0][15:0] col;
      logic [15:0]                       alpha;
      logic                              do_div;
   } div_stage_type;

   div_stage_type    st_ff [NS];
   div_stage_type    st_in [NS];
   logic [NS-1:0]    valid_ff, valid_in;
   logic [NS:0]      en;
   div_stage_type    init;

   // restoring division, DIV_BITS quotient bits per call
   function automatic div_stage_type div_step(input div_stage_type s);
      div_stage_type r;
      logic [16:0]   t;
      r = s;
      for (int b = 0; b < pxc_pkg::DIV_BITS; b++) begin
         for (int l = 0; l < pxc_pkg::NUM_COL; l++) begin
            t = {r.rem[l], r.low[l][15]};
            r.low[l] = {r.low[l][14:0], 1'b0};
            if (t >= {1'b0, r.alpha}) begin
               r.rem[l] = 16'(t - {1'b0, r.alpha});
               r.quo[l] = {r.quo[l][14:0], 1'b1};
            end else begin
               r.rem[l] = t[15:0];
               r.quo[l] = {r.quo[l][14:0], 1'b0};
            end
         end
      end
      return r;
   endfunction

   // 65535*c = (c<<16) - c: upper half is c-1, lower half is -c
   always_comb begin
      init.alpha  = in_chan[pxc_pkg::CH_ALPHA];
      init.do_div = premultiplied && (in_chan[pxc_pkg::CH_ALPHA] != 16'd0);
      for (int l = 0; l < pxc_pkg::NUM_COL; l++) begin
         init.col[l] = in_chan[l];
         init.sat[l] = in_chan[l] >= in_chan[pxc_pkg::CH_ALPHA];
         init.rem[l] = (in_chan[l] == 16'd0) ? 16'd0 : 16'(in_chan[l] - 16'd1);
         init.low[l] = 16'(16'd0 - in_chan[l]);
         init.quo[l] = 16'd0;
      end
   end

   always_comb begin
      en[NS] = out_ready;
      for (int i = NS - 1; i >= 0; i--) en[i] = !valid_ff[i] || en[i+1];
      for (int i = 0; i < NS; i++) begin
         if (i == 0) begin
            st_in[i]    = div_step(init);
            valid_in[i] = en[i] ? in_valid : valid_ff[i];
         end else begin
            st_in[i]    = div_step(st_ff[i-1]);
            valid_in[i] = en[i] ? valid_ff[i-1] : valid_ff[i];
         end
      end
   end

   assign in_ready  = en[0];
   assign out_valid = valid_ff[NS-1];

   always_comb begin
      for (int l = 0; l < pxc_pkg::NUM_COL; l++) begin
         if (!st_ff[NS-1].do_div)      out_chan[l] = st_ff[NS-1].col[l];
         else if (st_ff[NS-1].sat[l])  out_chan[l] = 16'hFFFF;
         else                          out_chan[l] = st_ff[NS-1].quo[l];
      end
      out_chan[pxc_pkg::CH_ALPHA] = st_ff[NS-1].alpha;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NS; i++) begin
         if (en[i]) st_ff[i] <= st_in[i];
      end
   end

endmodule

// ===== rtl/packed_rgba_to_rgba16_converter.sv =====
// Top level: packed pixel to 16-bit RGBA converter with register port.
`timescale 1ns / 1ps
// Takes one raw pixel of 1 to 8 bytes per transfer and returns one 16-bit
// RGBA transfer for it. Throughput is one pixel per clock while the output
// is not stalled. There are seven register stages: three unpack stages
// (byte assembly, field extraction by a 64-bit shifter per channel, bit
// replication) and four divider stages that resolve four quotient bits
// each for the premultiplied-alpha correction, which run on every pixel
// whether or not the mode is on. A stalled output holds the pipe; empty
// stages still fill, so up to seven pixels may be in flight.
// Registers sit at byte address 4*index on the APB port and must only be
// written while no pixel is in flight; pready is tied high.
module packed_rgba_to_rgba16_converter (
   input  logic                        clock,
   input  logic                        reset,
   // pixel input
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [63:0]                 req_raw_pixel,
   // RGBA16 result
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [15:0]                 rsp_red_value,
   output logic [15:0]                 rsp_green_value,
   output logic [15:0]                 rsp_blue_value,
   output logic [15:0]                 rsp_alpha_value,
   // register port
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [pxc_pkg::ADDR_W-1:0]  paddr,
   input  logic [pxc_pkg::DATA_W-1:0]  pwdata,
   output logic [pxc_pkg::DATA_W-1:0]  prdata,
   output logic                        pready
);

   pxc_pkg::cfg_type      cfg_ff, cfg_in;
   logic                  mid_valid, mid_ready;
   pxc_pkg::chan_vec_type mid_chan;
   pxc_pkg::chan_vec_type res_chan;
   logic                  wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   // register write decode; index seven and above is ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (pxc_pkg::reg_index_type'(paddr[4:2]))
            pxc_pkg::REG_BYTES_PER_PIXEL: cfg_in.bytes_per_pixel = pwdata[3:0];
            pxc_pkg::REG_BIG_ENDIAN:      cfg_in.big_endian = pwdata[0];
            pxc_pkg::REG_RED_LAYOUT:      cfg_in.layout[pxc_pkg::CH_RED] = pwdata[12:0];
            pxc_pkg::REG_GREEN_LAYOUT:    cfg_in.layout[pxc_pkg::CH_GREEN] = pwdata[12:0];
            pxc_pkg::REG_BLUE_LAYOUT:     cfg_in.layout[pxc_pkg::CH_BLUE] = pwdata[12:0];
            pxc_pkg::REG_ALPHA_LAYOUT:    cfg_in.layout[pxc_pkg::CH_ALPHA] = pwdata[12:0];
            pxc_pkg::REG_PREMULTIPLIED:   cfg_in.premultiplied = pwdata[0];
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   // read-back
   always_comb begin
      unique case (pxc_pkg::reg_index_type'(paddr[4:2]))
         pxc_pkg::REG_BYTES_PER_PIXEL: prdata = 32'(cfg_ff.bytes_per_pixel);
         pxc_pkg::REG_BIG_ENDIAN:      prdata = 32'(cfg_ff.big_endian);
         pxc_pkg::REG_RED_LAYOUT:      prdata = 32'(cfg_ff.layout[pxc_pkg::CH_RED]);
         pxc_pkg::REG_GREEN_LAYOUT:    prdata = 32'(cfg_ff.layout[pxc_pkg::CH_GREEN]);
         pxc_pkg::REG_BLUE_LAYOUT:     prdata = 32'(cfg_ff.layout[pxc_pkg::CH_BLUE]);
         pxc_pkg::REG_ALPHA_LAYOUT:    prdata = 32'(cfg_ff.layout[pxc_pkg::CH_ALPHA]);
         pxc_pkg::REG_PREMULTIPLIED:   prdata = 32'(cfg_ff.premultiplied);
         default:                      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bytes_per_pixel           <= pxc_pkg::RST_BYTES_PER_PIXEL;
         cfg_ff.big_endian                <= pxc_pkg::RST_BIG_ENDIAN;
         cfg_ff.layout[pxc_pkg::CH_RED]   <= pxc_pkg::RST_RED_LAYOUT;
         cfg_ff.layout[pxc_pkg::CH_GREEN] <= pxc_pkg::RST_GREEN_LAYOUT;
         cfg_ff.layout[pxc_pkg::CH_BLUE]  <= pxc_pkg::RST_BLUE_LAYOUT;
         cfg_ff.layout[pxc_pkg::CH_ALPHA] <= pxc_pkg::RST_ALPHA_LAYOUT;
         cfg_ff.premultiplied             <= pxc_pkg::RST_PREMULTIPLIED;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // unpack: assemble, extract, widen
   pxc_unpack u_unpack (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_raw    (req_raw_pixel),
      .out_valid (mid_valid),
      .out_ready (mid_ready),
      .out_chan  (mid_chan)
   );

   // premultiplied correction, final output register stage
   pxc_unpremul u_unpremul (
      .clock         (clock),
      .reset         (reset),
      .premultiplied (cfg_ff.premultiplied),
      .in_valid      (mid_valid),
      .in_ready      (mid_ready),
      .in_chan       (mid_chan),
      .out_valid     (rsp_valid),
      .out_ready     (rsp_ready),
      .out_chan      (res_chan)
   );

   assign rsp_red_value   = res_chan[pxc_pkg::CH_RED];
   assign rsp_green_value = res_chan[pxc_pkg::CH_GREEN];
   assign rsp_blue_value  = res_chan[pxc_pkg::CH_BLUE];
   assign rsp_alpha_value = res_chan[pxc_pkg::CH_ALPHA];

`ifndef NO_ASSERTIONS
   // input only backs up when every stage is full and the output is blocked
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("input stalled while pipeline has room");

   // reset empties the pipe
   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid straight after reset");
`endif

endmodule

// ===== tb/packed_rgba_to_rgba16_converter_test.sv =====
// Testbench for the packed pixel to RGBA16 converter: directed and random pixels.
`timescale 1ns / 1ps
module packed_rgba_to_rgba16_converter_test;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [63:0] req_raw_pixel = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_red_value, rsp_green_value, rsp_blue_value, rsp_alpha_value;
   logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [pxc_pkg::ADDR_W-1:0] paddr = '0;
   logic [pxc_pkg::DATA_W-1:0] pwdata = '0;
   logic [pxc_pkg::DATA_W-1:0] prdata;
   logic        pready;

   packed_rgba_to_rgba16_converter i_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // model copy of the registers
   logic [3:0]                   bpp_q;
   logic                         big_endian_q;
   logic [pxc_pkg::LAYOUT_W-1:0] layout_q [pxc_pkg::NUM_CHAN];
   logic                         premul_q;

   typedef struct {
      logic [15:0] red, green, blue, alpha;
   } rgba16_type;

   rgba16_type pending_pixels [$];
   int  failures = 0;
   int  quiet_cycles = 0;
   int  rsp_idle_left = 0;
   bit  idle_enabled = 1'b1;
   bit  hold_rsp = 1'b0;

   // widen one extracted field to 16 bits
   function automatic logic [15:0] widen_field(logic [63:0] word, logic [12:0] layout);
      int unsigned pos, wid, top;
      logic [63:0] mask, sel, v;
      logic [31:0] m;
      pos = 32'(layout[5:0]);
      wid = 32'(layout[12:6]);
      if (wid > 64) wid = 64;
      if (wid == 0) return 16'hFFFF;
      mask = (wid >= 64) ? '1 : ((64'd1 << wid) - 64'd1);
      sel = word & (mask << pos);
      if (wid > 16) begin
         top = pos + wid - 16;
         if (top >= 64) return 16'h0;
         return 16'((sel >> top) & 64'hFFFF);
      end
      v = (sel >> pos) & 64'hFFFF;
      case (wid)
         1: return v != 0 ? 16'hFFFF : 16'h0;
         2: m = 32'h5555 * v[15:0];
         3: m = (32'h9249 * v[15:0]) >> 2;
         4: m = 32'h1111 * v[15:0];
         5: m = (32'h8421 * v[15:0]) >> 4;
         6: m = (32'h1041 * v[15:0]) >> 2;
         7: m = (32'h4081 * v[15:0]) >> 5;
         8: m = 32'(v[15:0] | (v[15:0] << 8));
         16: m = 32'(v[15:0]);
         default: m = 32'((v >> (wid - 8)) | (v << (16 - wid)));
      endcase
      return m[15:0];
   endfunction

   function automatic logic [15:0] undo_alpha(logic [15:0] c, logic [15:0] a);
      logic [47:0] q;
      q = (48'd65535 * c) / a;
      return q > 65535 ? 16'hFFFF : q[15:0];
   endfunction

   function automatic rgba16_type unpack_pixel(logic [63:0] raw);
      int unsigned n;
      logic [63:0] word;
      rgba16_type p;
      n = 32'(bpp_q);
      word = '0;
      if (n < 1) n = 1;
      if (n > 8) n = 8;
      for (int k = 0; k < n; k++) begin
         if (big_endian_q) word = (word << 8) | 64'(raw[8*k +: 8]);
         else word = (word << 8) | 64'(raw[8*(n-1-k) +: 8]);
      end
      p.red   = widen_field(word, layout_q[pxc_pkg::CH_RED]);
      p.green = widen_field(word, layout_q[pxc_pkg::CH_GREEN]);
      p.blue  = widen_field(word, layout_q[pxc_pkg::CH_BLUE]);
      p.alpha = widen_field(word, layout_q[pxc_pkg::CH_ALPHA]);
      if (premul_q && p.alpha != 0) begin
         p.red   = undo_alpha(p.red, p.alpha);
         p.green = undo_alpha(p.green, p.alpha);
         p.blue  = undo_alpha(p.blue, p.alpha);
      end
      return p;
   endfunction

   task automatic set_reg(pxc_pkg::reg_index_type idx, logic [12:0] value);
      @(negedge clock);
      psel = 1'b1; pwrite = 1'b1;
      paddr = pxc_pkg::ADDR_W'(4 * idx);
      pwdata = pxc_pkg::DATA_W'(value);
      @(negedge clock);
      penable = 1'b1;
      @(negedge clock);
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
      case (idx)
         pxc_pkg::REG_BYTES_PER_PIXEL: bpp_q = value[3:0];
         pxc_pkg::REG_BIG_ENDIAN:      big_endian_q = value[0];
         pxc_pkg::REG_RED_LAYOUT:      layout_q[pxc_pkg::CH_RED] = value;
         pxc_pkg::REG_GREEN_LAYOUT:    layout_q[pxc_pkg::CH_GREEN] = value;
         pxc_pkg::REG_BLUE_LAYOUT:     layout_q[pxc_pkg::CH_BLUE] = value;
         pxc_pkg::REG_ALPHA_LAYOUT:    layout_q[pxc_pkg::CH_ALPHA] = value;
         pxc_pkg::REG_PREMULTIPLIED:   premul_q = value[0];
         default: ;
      endcase
   endtask

   // wait until every expected result has come, then let the clock run idle
   task automatic drain_pipe();
      wait (pending_pixels.size() == 0);
      repeat (10) @(negedge clock);
   endtask

   // offer one pixel; the expectation is queued at the accepting edge
   task automatic send_pixel(logic [63:0] raw);
      if (idle_enabled && $urandom_range(0, 5) == 0) repeat ($urandom_range(1, 16)) @(negedge clock);
      req_valid = 1'b1;
      req_raw_pixel = raw;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_pixels.push_back(unpack_pixel(raw));
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   // a back-to-back send keeps valid high between pixels
   task automatic send_run(int count);
      for (int i = 0; i < count; i++) begin
         @(negedge clock);
         req_valid = 1'b1;
         req_raw_pixel = {$urandom, $urandom};
         @(posedge clock);
         while (!req_ready) @(posedge clock);
         pending_pixels.push_back(unpack_pixel(req_raw_pixel));
      end
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   // receiver side: random idle bursts, and a long hold when asked
   always @(negedge clock) begin
      if (reset || hold_rsp) begin
         rsp_ready <= 1'b0;
      end else if (idle_enabled && rsp_idle_left > 0) begin
         rsp_ready <= 1'b0;
         rsp_idle_left <= rsp_idle_left - 1;
      end else if (idle_enabled && $urandom_range(0, 7) == 0) begin
         rsp_ready <= 1'b0;
         rsp_idle_left <= int'($urandom_range(0, 15));
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // compare each result transfer with the oldest expectation
   always @(posedge clock) begin
      rgba16_type want;
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (rsp_valid && rsp_ready) begin
            if (pending_pixels.size() == 0) begin
               $error("result transfer with nothing expected");
               failures++;
            end else begin
               want = pending_pixels.pop_front();
               if (rsp_red_value !== want.red) begin
                  $error("red_value expected %h got %h", want.red, rsp_red_value); failures++;
               end
               if (rsp_green_value !== want.green) begin
                  $error("green_value expected %h got %h", want.green, rsp_green_value); failures++;
               end
               if (rsp_blue_value !== want.blue) begin
                  $error("blue_value expected %h got %h", want.blue, rsp_blue_value); failures++;
               end
               if (rsp_alpha_value !== want.alpha) begin
                  $error("alpha_value expected %h got %h", want.alpha, rsp_alpha_value); failures++;
               end
            end
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (quiet_cycles > 5000) begin
         $display("Some tests failed");
         $finish;
      end
   end

   typedef struct {
      logic [63:0] raw;
      logic        checked;   // expected value typed in below
      rgba16_type  want;
   } stim_row_type;

   stim_row_type directed [] = '{
      '{64'h0000_0000_0000_0000, 1'b1, '{16'h0000, 16'h0000, 16'h0000, 16'hFFFF}},
      '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}},
      // big endian reset layout: first byte is red
      '{64'h0000_0000_0033_2211, 1'b1, '{16'h1111, 16'h2222, 16'h3333, 16'hFFFF}},
      '{64'hA5A5_5A5A_C3C3_3C3C, 1'b0, '{16'h0, 16'h0, 16'h0, 16'h0}}
   };

   // random layout with widths covering 0..127 and positions 0..63
   function automatic logic [12:0] any_layout();
      logic [6:0] w;
      case ($urandom_range(0, 5))
         0: w = 7'($urandom_range(65, 127));
         1: w = 7'($urandom_range(17, 64));
         2: w = 7'd0;
         default: w = 7'($urandom_range(1, 16));
      endcase
      return {w, 6'($urandom)};
   endfunction

   task automatic random_setup();
      set_reg(pxc_pkg::REG_BYTES_PER_PIXEL, 13'($urandom_range(0, 15)));
      set_reg(pxc_pkg::REG_BIG_ENDIAN, 13'($urandom_range(0, 1)));
      set_reg(pxc_pkg::REG_RED_LAYOUT, any_layout());
      set_reg(pxc_pkg::REG_GREEN_LAYOUT, any_layout());
      set_reg(pxc_pkg::REG_BLUE_LAYOUT, any_layout());
      set_reg(pxc_pkg::REG_ALPHA_LAYOUT, any_layout());
      set_reg(pxc_pkg::REG_PREMULTIPLIED, 13'($urandom_range(0, 1)));
   endtask

   initial begin
      bpp_q = pxc_pkg::RST_BYTES_PER_PIXEL;
      big_endian_q = pxc_pkg::RST_BIG_ENDIAN;
      layout_q[pxc_pkg::CH_RED] = pxc_pkg::RST_RED_LAYOUT;
      layout_q[pxc_pkg::CH_GREEN] = pxc_pkg::RST_GREEN_LAYOUT;
      layout_q[pxc_pkg::CH_BLUE] = pxc_pkg::RST_BLUE_LAYOUT;
      layout_q[pxc_pkg::CH_ALPHA] = pxc_pkg::RST_ALPHA_LAYOUT;
      premul_q = pxc_pkg::RST_PREMULTIPLIED;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset settings, typed-in expectations where obvious
      foreach (directed[i]) begin
         send_pixel(directed[i].raw);
         if (directed[i].checked) pending_pixels[$] = directed[i].want;
      end
      drain_pipe();

      // extremes: 8 bytes little endian, full-word and oversize widths, past bit 63
      set_reg(pxc_pkg::REG_BYTES_PER_PIXEL, 13'd8);
      set_reg(pxc_pkg::REG_BIG_ENDIAN, 13'd0);
      set_reg(pxc_pkg::REG_RED_LAYOUT, {7'd64, 6'd0});
      set_reg(pxc_pkg::REG_GREEN_LAYOUT, {7'd127, 6'd63});
      set_reg(pxc_pkg::REG_BLUE_LAYOUT, {7'd1, 6'd63});
      set_reg(pxc_pkg::REG_ALPHA_LAYOUT, {7'd16, 6'd48});
      set_reg(pxc_pkg::REG_PREMULTIPLIED, 13'd1);
      send_pixel(64'hFFFF_0000_0000_0000);
      pending_pixels[$] = '{16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF};
      send_pixel(64'h0000_8000_0000_0001);   // zero alpha: no division
      send_pixel(64'h8000_1234_5678_9ABC);
      send_pixel(64'h7FFF_FFFF_FFFF_FFFF);
      drain_pipe();
      // byte counts zero and over eight, every narrow width
      set_reg(pxc_pkg::REG_BYTES_PER_PIXEL, 13'd0);
      for (int w = 1; w <= 16; w++) begin
         set_reg(pxc_pkg::REG_RED_LAYOUT, {7'(w), 6'd0});
         send_pixel({$urandom, $urandom});
         send_pixel(64'hFF);
         drain_pipe();
      end
      set_reg(pxc_pkg::REG_BYTES_PER_PIXEL, 13'd15);
      set_reg(pxc_pkg::REG_BIG_ENDIAN, 13'd1);
      send_pixel(64'h0123_4567_89AB_CDEF);
      drain_pipe();

      // random phases
      for (int phase = 0; phase < 30; phase++) begin
         random_setup();
         if (phase == 10) begin
            // long receiver hold while the sender keeps offering
            hold_rsp = 1'b1;
            fork
               send_run(40);
               begin repeat (200) @(negedge clock); hold_rsp = 1'b0; end
            join
         end else if (phase >= 26) begin
            idle_enabled = 1'b0;
            send_run(60);
         end else begin
            for (int i = 0; i < 60; i++) begin
               if (i == 30) drain_pipe();   // sender pause until empty
               send_pixel({$urandom, $urandom});
            end
         end
         drain_pipe();
      end

      if (failures == 0 && pending_pixels.size() == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/pxc_pkg.sv
rtl/pxc_unpack.sv
rtl/pxc_unpremul.sv
rtl/packed_rgba_to_rgba16_converter.sv
tb/packed_rgba_to_rgba16_converter_test.sv
